FILE: src/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// AES-CTR keystream package
// Shared types, constants and AES byte functions.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam logic [1:0] REG_KEY_LOW   = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
    localparam logic [1:0] REG_SEED_LOW  = 2'd2;
    localparam logic [1:0] REG_SEED_HIGH = 2'd3;

    localparam int BLOCK_BYTES = 16;
    localparam int NUM_ROUNDS  = 10;

    // Controller to datapath commands
    typedef struct packed {
        logic start_block;  // load counter ^ key, reset round key to cipher key
        logic do_round;     // run one round and advance the round key
        logic last_round;   // omit mix columns
        logic advance_ctr;  // step the counter
    } dp_cmd_t;

    typedef logic [7:0] byte_t;

    function automatic byte_t sbox(input byte_t a);
        byte_t t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

FILE: src/aesctr_datapath.sv
// ----------------------------------------------------------------------------
// AES-CTR datapath
// Counter, key registers, one AES round unit with on-the-fly key expansion.
// ----------------------------------------------------------------------------
module aesctr_datapath import aesctr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_idx,
    input  logic [63:0]  cfg_data,
    input  dp_cmd_t      cmd,
    output logic [127:0] state_out
);

    logic [127:0] key_reg;
    logic [127:0] ctr_reg, ctr_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rcon_reg, rcon_next;

    byte_t s [16];
    byte_t t [16];
    byte_t m [16];
    byte_t rk_b [16];
    byte_t nk [16];
    byte_t tw [4];

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            s[k]    = st_reg[8*k +: 8];
            rk_b[k] = rk_reg[8*k +: 8];
        end
        // key schedule step
        tw[0] = sbox(rk_b[13]) ^ rcon_reg;
        tw[1] = sbox(rk_b[14]);
        tw[2] = sbox(rk_b[15]);
        tw[3] = sbox(rk_b[12]);
        for (int j = 0; j < 4; j++) begin
            nk[j]      = rk_b[j] ^ tw[j];
            nk[4 + j]  = rk_b[4 + j] ^ nk[j];
            nk[8 + j]  = rk_b[8 + j] ^ nk[4 + j];
            nk[12 + j] = rk_b[12 + j] ^ nk[8 + j];
        end
        // sub bytes and shift rows
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c + r] = sbox(s[4*((c + r) & 3) + r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            byte_t all;
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        st_next   = st_reg;
        rk_next   = rk_reg;
        rcon_next = rcon_reg;
        if (cmd.start_block) begin
            st_next   = ctr_reg ^ key_reg;
            rk_next   = key_reg;
            rcon_next = 8'h01;
        end else if (cmd.do_round) begin
            for (int k = 0; k < 16; k++) begin
                st_next[8*k +: 8] = (cmd.last_round ? t[k] : m[k]) ^ nk[k];
                rk_next[8*k +: 8] = nk[k];
            end
            rcon_next = xtime(rcon_reg);
        end
    end

    always_comb begin
        ctr_next = ctr_reg;
        if (cmd.advance_ctr) begin
            ctr_next = ctr_reg + 128'd1;
        end
        if (cfg_we && cfg_idx == REG_SEED_LOW) begin
            ctr_next[63:0] = cfg_data;
        end
        if (cfg_we && cfg_idx == REG_SEED_HIGH) begin
            ctr_next[127:64] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            ctr_reg <= '0;
        end else begin
            ctr_reg <= ctr_next;
            if (cfg_we && cfg_idx == REG_KEY_LOW) begin
                key_reg[63:0] <= cfg_data;
            end
            if (cfg_we && cfg_idx == REG_KEY_HIGH) begin
                key_reg[127:64] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_reg   <= st_next;
        rk_reg   <= rk_next;
        rcon_reg <= rcon_next;
    end

    assign state_out = st_reg;

endmodule

FILE: src/aesctr_ctrl.sv
// ----------------------------------------------------------------------------
// AES-CTR controller
// Sequences blocks and rounds of one request and owns the output register.
// ----------------------------------------------------------------------------
module aesctr_ctrl import aesctr_pkg::*; #(
    parameter int MAX_REQUEST_BYTES = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [10:0]  s_byte_count,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [63:0]  m_stream_low,
    output logic [63:0]  m_stream_high,
    output logic [4:0]   m_valid_bytes,
    output logic         m_last_block,
    output dp_cmd_t      cmd,
    input  logic [127:0] state_in
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [10:0] MAX_BYTES = 11'(MAX_REQUEST_BYTES);

    logic [1:0]  state_reg, state_next;
    logic [10:0] remain_reg, remain_next;
    logic [3:0]  round_reg, round_next;
    logic        ovalid_reg, ovalid_next;
    logic [63:0] olow_reg, ohigh_reg;
    logic [4:0]  obytes_reg;
    logic        olast_reg;
    logic [4:0]  take;
    logic        emit;

    assign take = (remain_reg < 11'(BLOCK_BYTES)) ? remain_reg[4:0] : 5'(BLOCK_BYTES);
    assign s_ready = (state_reg == ST_IDLE);
    assign emit = (state_reg == ST_OUT) && (!ovalid_reg || m_ready);

    always_comb begin
        state_next  = state_reg;
        remain_next = remain_reg;
        round_next  = round_reg;
        ovalid_next = ovalid_reg && !m_ready;
        cmd         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    remain_next = (s_byte_count > MAX_BYTES) ? MAX_BYTES : s_byte_count;
                    if (s_byte_count != 11'd0) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                cmd.start_block = 1'b1;
                round_next      = 4'd1;
                state_next      = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.do_round   = 1'b1;
                cmd.last_round = (round_reg == 4'(NUM_ROUNDS));
                round_next     = round_reg + 4'd1;
                if (round_reg == 4'(NUM_ROUNDS)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the finished block until the output register frees
                if (emit) begin
                    cmd.advance_ctr = 1'b1;
                    ovalid_next     = 1'b1;
                    remain_next     = remain_reg - 11'(take);
                    state_next      = (remain_reg == 11'(take)) ? ST_IDLE : ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            remain_reg <= '0;
            round_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            remain_reg <= remain_next;
            round_reg  <= round_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            olow_reg   <= state_in[63:0];
            ohigh_reg  <= state_in[127:64];
            obytes_reg <= take;
            olast_reg  <= (remain_reg == 11'(take));
        end
    end

    assign m_valid       = ovalid_reg;
    assign m_stream_low  = olow_reg;
    assign m_stream_high = ohigh_reg;
    assign m_valid_bytes = obytes_reg;
    assign m_last_block  = olast_reg;

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_stream_low))
        else $error("result dropped while stalled");
    a_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_valid_bytes != 5'd0 && m_valid_bytes <= 5'(BLOCK_BYTES))
        else $error("valid byte count out of range");
    a_partial_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_valid_bytes != 5'(BLOCK_BYTES) |-> m_last_block)
        else $error("partial block not last");
`endif

endmodule

FILE: src/aes_ctr_keystream_generator.sv
// ----------------------------------------------------------------------------
// AES-128 CTR keystream generator
// Emits ceil(min(count, MAX_REQUEST_BYTES)/16) keystream blocks per request,
// each the AES-128 encryption of the running 128-bit counter. A single round
// unit runs one round per cycle; each block goes through key load, ten rounds
// and hand-off, which waits while the output is stalled. A new request is
// taken once the previous one has put its last block in the output register.
// Configuration writes are taken at any time and must be made idle.
// ----------------------------------------------------------------------------
module aes_ctr_keystream_generator import aesctr_pkg::*; #(
    parameter int MAX_REQUEST_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [10:0] s_byte_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_stream_low,
    output logic [63:0] m_stream_high,
    output logic [4:0]  m_valid_bytes,
    output logic        m_last_block
);

    dp_cmd_t      cmd;
    logic [127:0] state_w;

    assign cfg_ready = 1'b1;

    aesctr_ctrl #(.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_byte_count,
        .m_valid, .m_ready, .m_stream_low, .m_stream_high,
        .m_valid_bytes, .m_last_block, .cmd, .state_in(state_w)
    );

    aesctr_datapath u_dp (
        .aclk, .aresetn,
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
        .cmd, .state_out(state_w)
    );

endmodule
